>>> hdl/tileable_value_noise_texel_unit_macros.svh
// ----------------------------------------------------------------------------
// tileable_value_noise_texel_unit_macros.svh
// assertion macros used by the texel unit checker
// ----------------------------------------------------------------------------
`ifndef TILEABLE_VALUE_NOISE_TEXEL_UNIT_MACROS_SVH
`define TILEABLE_VALUE_NOISE_TEXEL_UNIT_MACROS_SVH

// property checked on every rising edge while out of reset
`define TVN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked on every rising edge, reset included
`define TVN_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/tvn_pkg.sv
// ----------------------------------------------------------------------------
// tvn_pkg
// constants and types of the tileable value noise texel unit
// ----------------------------------------------------------------------------
package tvn_pkg;

  // texture geometry
  localparam int TEXTURE_SIZE = 64;
  localparam int COARSE_CELLS = 4;
  localparam int OCTAVES      = 3;
  localparam int CORNERS      = 4;

  // field and port widths
  localparam int COORD_W     = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int VALUE_W     = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int REG_W       = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int REG_IDX_LSB = 2;

  // lattice index width covers the finest octave
  localparam int CIDX_W = (COARSE_CELLS * 4 > 1) ? $clog2(COARSE_CELLS * 4) : 1;

  // hash constants
  localparam logic [31:0] HASH_KX = 32'h8DA6B343;
  localparam logic [31:0] HASH_KY = 32'hD8163841;
  localparam logic [31:0] HASH_KS = 32'hCB1AB31F;
  localparam logic [31:0] HASH_KM = 32'h5BD1E995;
  localparam int HASH_SHIFT_A = 13;
  localparam int HASH_SHIFT_B = 15;
  // only the low bits of the final mix feed the corner byte
  localparam int MIX_W = HASH_SHIFT_B + VALUE_W;

  // fraction and smoothstep
  localparam int FRAC_W      = 8;
  localparam int FSQ_W       = 2 * FRAC_W;
  localparam int EASE_W      = FRAC_W + 1;
  localparam int EASE_BIAS_W = 10;
  localparam logic [EASE_BIAS_W-1:0] EASE_BIAS = 10'd768;
  localparam int EASE_PROD_W = FSQ_W + EASE_BIAS_W;
  localparam int EASE_SHIFT  = 16;
  localparam logic [EASE_W-1:0] WEIGHT_ONE = 9'd256;

  // bilinear blend widths
  localparam int ROW_W   = 16;
  localparam int ROW_P_W = ROW_W + 1;
  localparam int COL_P_W = ROW_W + EASE_W;
  localparam int COL_SHIFT = 16;

  // octave sum and floor divide by 7: floor(s * 4682 / 2^15) is exact below 5461
  localparam int SUM_W       = VALUE_W + 3;
  localparam int DIV7_MUL    = 4682;
  localparam int DIV7_SHIFT  = 15;
  localparam int DIV7_PROD_W = SUM_W + 13;

  // shaping: (n - 88) * 255 / 100, exact as d * 1336965 >> 19 for d up to 100
  localparam logic [VALUE_W-1:0] SHAPE_OFFSET = 8'd88;
  localparam logic [VALUE_W-1:0] SHAPE_CLAMP  = 8'd101;
  localparam int SCALE_MUL    = 1336965;
  localparam int SCALE_SHIFT  = 19;
  localparam int SCALE_PROD_W = VALUE_W + 21;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 8'hFF;

  // register stages from input register to output register
  localparam int PIPE_DEPTH = 8;

  typedef enum logic [1:0] {
    REG_SEED_COARSE = 2'd0,
    REG_SEED_MIDDLE = 2'd1,
    REG_SEED_FINE   = 2'd2
  } cfg_reg_t;

  localparam logic [REG_W-1:0] SEED_COARSE_RESET = 32'd11;
  localparam logic [REG_W-1:0] SEED_MIDDLE_RESET = 32'd13;
  localparam logic [REG_W-1:0] SEED_FINE_RESET   = 32'd17;

endpackage

>>> hdl/tileable_value_noise_texel_unit.sv
// ----------------------------------------------------------------------------
// tileable_value_noise_texel_unit: three-octave value noise mist texel
// each texel passes the input register plus 7 pipe stages to a valid result
// one texel per cycle; a stall holds a full stage only if all later stages are full
// rst_n (sync, active low) empties the pipe and reloads the seeds 11, 13, 17
// ----------------------------------------------------------------------------
module tileable_value_noise_texel_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tvn_pkg::IN_TDATA_W-1:0]   in_tdata,   // texel_x[5:0], texel_y[11:6]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tvn_pkg::OUT_TDATA_W-1:0]  out_tdata,  // mist_value[7:0]
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tvn_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tvn_pkg::REG_W-1:0]        pwdata,
  output logic [tvn_pkg::REG_W-1:0]        prdata,
  output logic                             pready
);

  // ---------------------------------------------------------------- config
  logic [tvn_pkg::REG_W-1:0] seed_r [tvn_pkg::OCTAVES];
  tvn_pkg::cfg_reg_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = tvn_pkg::cfg_reg_t'(paddr[tvn_pkg::REG_IDX_LSB +: 2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r[0] <= tvn_pkg::SEED_COARSE_RESET;
      seed_r[1] <= tvn_pkg::SEED_MIDDLE_RESET;
      seed_r[2] <= tvn_pkg::SEED_FINE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        tvn_pkg::REG_SEED_COARSE: seed_r[0] <= pwdata;
        tvn_pkg::REG_SEED_MIDDLE: seed_r[1] <= pwdata;
        tvn_pkg::REG_SEED_FINE:   seed_r[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tvn_pkg::REG_SEED_COARSE: prdata = seed_r[0];
      tvn_pkg::REG_SEED_MIDDLE: prdata = seed_r[1];
      tvn_pkg::REG_SEED_FINE:   prdata = seed_r[2];
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- pipe control
  logic [tvn_pkg::PIPE_DEPTH-1:0] vld_r;
  logic [tvn_pkg::PIPE_DEPTH-1:0] adv;

  // a stage moves when it is empty or the stage after it moves
  assign adv[tvn_pkg::PIPE_DEPTH-1] = !vld_r[tvn_pkg::PIPE_DEPTH-1] || out_tready;
  for (genvar k = 0; k < tvn_pkg::PIPE_DEPTH - 1; k++) begin : g_adv
    assign adv[k] = !vld_r[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv[0]) begin
      vld_r[0] <= in_tvalid;
    end
  end

  for (genvar k = 1; k < tvn_pkg::PIPE_DEPTH; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[tvn_pkg::PIPE_DEPTH-1];

  // ----------------------------------------------------- stage 0: texel in
  logic [tvn_pkg::COORD_W-1:0] tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tx_r <= in_tdata[tvn_pkg::COORD_W-1:0];
      ty_r <= in_tdata[2*tvn_pkg::COORD_W-1:tvn_pkg::COORD_W];
    end
  end

  // ------------------------------------------------------------- octaves
  logic [tvn_pkg::VALUE_W-1:0] oct_r [tvn_pkg::OCTAVES];

  for (genvar o = 0; o < tvn_pkg::OCTAVES; o++) begin : g_oct
    localparam int Cells   = tvn_pkg::COARSE_CELLS << o;
    localparam int SizeRaw = tvn_pkg::TEXTURE_SIZE / Cells;
    localparam int Size    = (SizeRaw == 0) ? 1 : SizeRaw;

    logic [tvn_pkg::COORD_W-1:0] cx, cy;
    logic [tvn_pkg::CIDX_W-1:0]  lx [2];
    logic [tvn_pkg::CIDX_W-1:0]  ly [2];
    logic [tvn_pkg::FRAC_W-1:0]  fx, fy;
    logic [31:0]                 seed_term;

    // stage 1: pre-hash of each corner, fractions
    logic [31:0]                 h0_r [tvn_pkg::CORNERS];
    logic [tvn_pkg::FRAC_W-1:0]  fx1_r, fy1_r;
    // stage 2: low bits of the multiplied hash, squared fractions
    logic [tvn_pkg::MIX_W-1:0]   mix_r [tvn_pkg::CORNERS];
    logic [tvn_pkg::FRAC_W-1:0]  fx2_r, fy2_r;
    logic [tvn_pkg::FSQ_W-1:0]   fxsq_r, fysq_r;
    // stage 3: corner bytes, eased weights
    logic [tvn_pkg::VALUE_W-1:0] cb_r [tvn_pkg::CORNERS];
    logic [tvn_pkg::EASE_W-1:0]  sx_r, sy3_r;
    // stage 4: horizontal blends
    logic [tvn_pkg::ROW_W-1:0]   top_r, bot_r;
    logic [tvn_pkg::EASE_W-1:0]  sy4_r;

    logic [tvn_pkg::EASE_PROD_W-1:0] ex, ey;
    logic [tvn_pkg::ROW_P_W-1:0]     top_nxt, bot_nxt;
    logic [tvn_pkg::COL_P_W-1:0]     col_nxt;

    assign cx = tvn_pkg::COORD_W'(tx_r / Size);
    assign cy = tvn_pkg::COORD_W'(ty_r / Size);
    assign fx = tvn_pkg::FRAC_W'((32'(tx_r % Size) << tvn_pkg::FRAC_W) / Size);
    assign fy = tvn_pkg::FRAC_W'((32'(ty_r % Size) << tvn_pkg::FRAC_W) / Size);

    // lattice corners wrap so the texture tiles
    assign lx[0] = tvn_pkg::CIDX_W'(32'(cx) % Cells);
    assign lx[1] = tvn_pkg::CIDX_W'((32'(cx) + 32'd1) % Cells);
    assign ly[0] = tvn_pkg::CIDX_W'(32'(cy) % Cells);
    assign ly[1] = tvn_pkg::CIDX_W'((32'(cy) + 32'd1) % Cells);

    assign seed_term = 32'(seed_r[o] * tvn_pkg::HASH_KS);

    for (genvar c = 0; c < tvn_pkg::CORNERS; c++) begin : g_corner
      logic [31:0] h1;

      // corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
      always_ff @(posedge clk) begin
        if (adv[1]) begin
          h0_r[c] <= 32'(32'(lx[c % 2]) * tvn_pkg::HASH_KX)
                   ^ 32'(32'(ly[c / 2]) * tvn_pkg::HASH_KY)
                   ^ seed_term;
        end
      end

      assign h1 = h0_r[c] ^ (h0_r[c] >> tvn_pkg::HASH_SHIFT_A);

      always_ff @(posedge clk) begin
        if (adv[2]) begin
          mix_r[c] <= tvn_pkg::MIX_W'(h1[tvn_pkg::MIX_W-1:0]
                                    * tvn_pkg::HASH_KM[tvn_pkg::MIX_W-1:0]);
        end
        if (adv[3]) begin
          cb_r[c] <= mix_r[c][tvn_pkg::VALUE_W-1:0]
                   ^ mix_r[c][tvn_pkg::MIX_W-1 -: tvn_pkg::VALUE_W];
        end
      end
    end

    // smoothstep f*f*(768-2f) >> 16
    assign ex = tvn_pkg::EASE_PROD_W'(fxsq_r)
              * tvn_pkg::EASE_PROD_W'(tvn_pkg::EASE_BIAS
                                      - tvn_pkg::EASE_BIAS_W'({fx2_r, 1'b0}));
    assign ey = tvn_pkg::EASE_PROD_W'(fysq_r)
              * tvn_pkg::EASE_PROD_W'(tvn_pkg::EASE_BIAS
                                      - tvn_pkg::EASE_BIAS_W'({fy2_r, 1'b0}));

    assign top_nxt = tvn_pkg::ROW_P_W'(cb_r[0]) * tvn_pkg::ROW_P_W'(tvn_pkg::WEIGHT_ONE - sx_r)
                   + tvn_pkg::ROW_P_W'(cb_r[1]) * tvn_pkg::ROW_P_W'(sx_r);
    assign bot_nxt = tvn_pkg::ROW_P_W'(cb_r[2]) * tvn_pkg::ROW_P_W'(tvn_pkg::WEIGHT_ONE - sx_r)
                   + tvn_pkg::ROW_P_W'(cb_r[3]) * tvn_pkg::ROW_P_W'(sx_r);

    assign col_nxt = tvn_pkg::COL_P_W'(top_r) * tvn_pkg::COL_P_W'(tvn_pkg::WEIGHT_ONE - sy4_r)
                   + tvn_pkg::COL_P_W'(bot_r) * tvn_pkg::COL_P_W'(sy4_r);

    always_ff @(posedge clk) begin
      if (adv[1]) begin
        fx1_r <= fx;
        fy1_r <= fy;
      end
      if (adv[2]) begin
        fx2_r  <= fx1_r;
        fy2_r  <= fy1_r;
        fxsq_r <= tvn_pkg::FSQ_W'(fx1_r) * tvn_pkg::FSQ_W'(fx1_r);
        fysq_r <= tvn_pkg::FSQ_W'(fy1_r) * tvn_pkg::FSQ_W'(fy1_r);
      end
      if (adv[3]) begin
        sx_r  <= tvn_pkg::EASE_W'(ex >> tvn_pkg::EASE_SHIFT);
        sy3_r <= tvn_pkg::EASE_W'(ey >> tvn_pkg::EASE_SHIFT);
      end
      if (adv[4]) begin
        top_r <= tvn_pkg::ROW_W'(top_nxt);
        bot_r <= tvn_pkg::ROW_W'(bot_nxt);
        sy4_r <= sy3_r;
      end
      if (adv[5]) begin
        oct_r[o] <= tvn_pkg::VALUE_W'(col_nxt >> tvn_pkg::COL_SHIFT);
      end
    end
  end

  // ----------------------------------------- stage 6: weighted sum over 7
  logic [tvn_pkg::SUM_W-1:0]       sum_nxt;
  logic [tvn_pkg::DIV7_PROD_W-1:0] div7_prod;
  logic [tvn_pkg::VALUE_W-1:0]     avg_r;

  // weights 4, 2, 1 from coarse to fine
  assign sum_nxt = (tvn_pkg::SUM_W'(oct_r[0]) << 2)
                 + (tvn_pkg::SUM_W'(oct_r[1]) << 1)
                 + tvn_pkg::SUM_W'(oct_r[2]);
  assign div7_prod = tvn_pkg::DIV7_PROD_W'(sum_nxt)
                   * tvn_pkg::DIV7_PROD_W'(tvn_pkg::DIV7_MUL);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      avg_r <= tvn_pkg::VALUE_W'(div7_prod >> tvn_pkg::DIV7_SHIFT);
    end
  end

  // ------------------------------------------- stage 7: shape and clamp
  logic [tvn_pkg::VALUE_W-1:0]      shape_diff;
  logic [tvn_pkg::SCALE_PROD_W-1:0] scale_prod;
  logic [tvn_pkg::VALUE_W-1:0]      shaped_nxt;
  logic [tvn_pkg::VALUE_W-1:0]      out_r;

  assign shape_diff = avg_r - tvn_pkg::SHAPE_OFFSET;
  assign scale_prod = tvn_pkg::SCALE_PROD_W'(shape_diff)
                    * tvn_pkg::SCALE_PROD_W'(tvn_pkg::SCALE_MUL);

  always_comb begin
    if (avg_r < tvn_pkg::SHAPE_OFFSET) begin
      // negative results truncate toward zero and clamp to zero
      shaped_nxt = '0;
    end else if (shape_diff >= tvn_pkg::SHAPE_CLAMP) begin
      shaped_nxt = tvn_pkg::VALUE_MAX;
    end else begin
      shaped_nxt = tvn_pkg::VALUE_W'(scale_prod >> tvn_pkg::SCALE_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      out_r <= shaped_nxt;
    end
  end

  assign out_tdata = out_r;

endmodule

>>> hdl/tvn_checker.sv
// ----------------------------------------------------------------------------
// tvn_checker
// port-level checks of the texel unit, bound to the top level
// ----------------------------------------------------------------------------
`include "tileable_value_noise_texel_unit_macros.svh"

module tvn_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tvn_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a reset cycle leaves no result behind
  `TVN_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // a result that is not taken stays offered
  `TVN_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")

  // and keeps its value while stalled
  `TVN_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled result changed")

  // with the output side free, the pipe always takes a new texel
  `TVN_ASSERT(a_in_free, clk, rst_n, (!out_tvalid || out_tready) |-> in_tready, "input blocked with free output")

endmodule

bind tileable_value_noise_texel_unit tvn_checker u_tvn_checker (.*);

>>> tb/tileable_value_noise_texel_unit_tb.sv
// ----------------------------------------------------------------------------
// tileable_value_noise_texel_unit_tb
// streams texel coordinates through the noise unit under several seed settings
// and traffic patterns; all but preset results are checked against a local
// model of the three-octave value noise, blend, divide and clamp
// ----------------------------------------------------------------------------
module tileable_value_noise_texel_unit_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RESET_CYCLES  = 6;
  localparam int PHASES        = 8;
  localparam int PHASE_TEXELS  = 240;
  localparam int REPORT_LIMIT  = 10;
  localparam int UNMAPPED_REG  = 3;
  localparam int MIST_OFFSET   = 88;
  localparam int MIST_SCALE    = 255;
  localparam int MIST_RANGE    = 100;
  localparam int OCTAVE_WEIGHT = 7;
  localparam int COORD_W       = tvn_pkg::COORD_W;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;
  localparam int REG_W         = tvn_pkg::REG_W;
  localparam int VALUE_W       = tvn_pkg::VALUE_W;
  localparam int CFG_ADDR_W    = tvn_pkg::CFG_ADDR_W;

  typedef enum logic {ROW_TEXEL, ROW_WRITE} row_kind_t;

  // texel rows: a = x, b = y; write rows: a = register index, b = value
  typedef struct {
    row_kind_t    kind;
    int           a;
    logic [31:0]  b;
    bit           typed;
    logic [7:0]   mist;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_TEXEL, 0, 32'd0, 1'b0, 8'd0},
    '{ROW_TEXEL, 63, 32'd63, 1'b0, 8'd0},
    '{ROW_TEXEL, 0, 32'd63, 1'b0, 8'd0},
    '{ROW_TEXEL, 63, 32'd0, 1'b0, 8'd0},
    '{ROW_TEXEL, 15, 32'd16, 1'b0, 8'd0},
    '{ROW_TEXEL, 16, 32'd15, 1'b0, 8'd0},
    '{ROW_TEXEL, 3, 32'd4, 1'b0, 8'd0},
    '{ROW_TEXEL, 7, 32'd8, 1'b0, 8'd0},
    '{ROW_TEXEL, 32, 32'd31, 1'b0, 8'd0},
    '{ROW_WRITE, int'(tvn_pkg::REG_SEED_COARSE), 32'd0, 1'b0, 8'd0},
    '{ROW_WRITE, int'(tvn_pkg::REG_SEED_MIDDLE), 32'd0, 1'b0, 8'd0},
    '{ROW_WRITE, int'(tvn_pkg::REG_SEED_FINE), 32'd0, 1'b0, 8'd0},
    // zero seeds hash the origin corner to zero in every octave
    '{ROW_TEXEL, 0, 32'd0, 1'b1, 8'd0},
    // write to an unmapped address must leave the seeds alone
    '{ROW_WRITE, UNMAPPED_REG, 32'hFFFF_FFFF, 1'b0, 8'd0},
    '{ROW_TEXEL, 0, 32'd0, 1'b1, 8'd0},
    '{ROW_WRITE, int'(tvn_pkg::REG_SEED_COARSE), 32'hFFFF_FFFF, 1'b0, 8'd0},
    '{ROW_WRITE, int'(tvn_pkg::REG_SEED_MIDDLE), 32'hFFFF_FFFF, 1'b0, 8'd0},
    '{ROW_WRITE, int'(tvn_pkg::REG_SEED_FINE), 32'hFFFF_FFFF, 1'b0, 8'd0},
    '{ROW_TEXEL, 0, 32'd0, 1'b0, 8'd0},
    '{ROW_TEXEL, 63, 32'd63, 1'b0, 8'd0},
    '{ROW_TEXEL, 42, 32'd21, 1'b0, 8'd0},
    '{ROW_TEXEL, 21, 32'd42, 1'b0, 8'd0},
    '{ROW_TEXEL, 1, 32'd62, 1'b0, 8'd0}
  };

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [tvn_pkg::IN_TDATA_W-1:0]    in_tdata = '0;    // texel_x[5:0], texel_y[11:6]
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [tvn_pkg::OUT_TDATA_W-1:0]   out_tdata;        // mist_value[7:0]
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]             paddr = '0;
  logic [REG_W-1:0]                  pwdata = '0;
  logic [REG_W-1:0]                  prdata;
  logic                              pready;

  logic [REG_W-1:0]        seed_coarse_q = tvn_pkg::SEED_COARSE_RESET;
  logic [REG_W-1:0]        seed_middle_q = tvn_pkg::SEED_MIDDLE_RESET;
  logic [REG_W-1:0]        seed_fine_q   = tvn_pkg::SEED_FINE_RESET;

  logic [VALUE_W-1:0]      pending_mist [$];
  logic [VALUE_W-1:0]      mist_want;
  bit                      texel_typed = 1'b0;
  logic [VALUE_W-1:0]      texel_mist = '0;
  int                      gap_pct = 0;
  int                      stall_pct = 0;
  int                      fail_count = 0;

  tileable_value_noise_texel_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] corner_byte(int x, int y, logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] lx;
    logic [31:0] ly;
    lx = x;
    ly = y;
    h = (lx * tvn_pkg::HASH_KX) ^ (ly * tvn_pkg::HASH_KY) ^ (seed * tvn_pkg::HASH_KS);
    h = h ^ (h >> tvn_pkg::HASH_SHIFT_A);
    h = h * tvn_pkg::HASH_KM;
    h = h ^ (h >> tvn_pkg::HASH_SHIFT_B);
    return h[7:0];
  endfunction

  function automatic int smoothstep(int f);
    return (f * f * (int'(tvn_pkg::EASE_BIAS) - 2 * f)) >> tvn_pkg::EASE_SHIFT;
  endfunction

  function automatic int octave_level(int x, int y, int cells, logic [31:0] seed);
    int span;
    int cx;
    int cy;
    int sx;
    int sy;
    int c00;
    int c10;
    int c01;
    int c11;
    int top;
    int bottom;
    span = tvn_pkg::TEXTURE_SIZE / cells;
    if (span == 0) begin
      span = 1;
    end
    cx = x / span;
    cy = y / span;
    sx = smoothstep((x % span) * 256 / span);
    sy = smoothstep((y % span) * 256 / span);
    c00 = corner_byte(cx % cells, cy % cells, seed);
    c10 = corner_byte((cx + 1) % cells, cy % cells, seed);
    c01 = corner_byte(cx % cells, (cy + 1) % cells, seed);
    c11 = corner_byte((cx + 1) % cells, (cy + 1) % cells, seed);
    top = c00 * (256 - sx) + c10 * sx;
    bottom = c01 * (256 - sx) + c11 * sx;
    return (top * (256 - sy) + bottom * sy) >> tvn_pkg::COL_SHIFT;
  endfunction

  function automatic logic [VALUE_W-1:0] mist_of(int x, int y);
    int sum;
    int shaped;
    sum = 4 * octave_level(x, y, tvn_pkg::COARSE_CELLS, seed_coarse_q)
        + 2 * octave_level(x, y, 2 * tvn_pkg::COARSE_CELLS, seed_middle_q)
        + octave_level(x, y, 4 * tvn_pkg::COARSE_CELLS, seed_fine_q);
    // signed divide truncates toward zero
    shaped = (sum / OCTAVE_WEIGHT - MIST_OFFSET) * MIST_SCALE / MIST_RANGE;
    if (shaped < 0) begin
      shaped = 0;
    end
    if (shaped > 255) begin
      shaped = 255;
    end
    return shaped[VALUE_W-1:0];
  endfunction

  task automatic flag_failure(string what, int want, int got);
    if (fail_count < REPORT_LIMIT) begin
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
    fail_count++;
  endtask

  task automatic read_seed_reg(int idx, output logic [REG_W-1:0] value);
    psel = 1'b1;
    pwrite = 1'b0;
    penable = 1'b0;
    paddr = CFG_ADDR_W'(idx << tvn_pkg::REG_IDX_LSB);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    value = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_seed_reg(int idx, logic [REG_W-1:0] value);
    logic [REG_W-1:0] readback;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = CFG_ADDR_W'(idx << tvn_pkg::REG_IDX_LSB);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      int'(tvn_pkg::REG_SEED_COARSE): seed_coarse_q = value;
      int'(tvn_pkg::REG_SEED_MIDDLE): seed_middle_q = value;
      int'(tvn_pkg::REG_SEED_FINE):   seed_fine_q = value;
      default: ;
    endcase
    if (idx < UNMAPPED_REG) begin
      read_seed_reg(idx, readback);
      if (readback !== value) begin
        flag_failure("seed readback", value, readback);
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_mist.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // called on a falling edge; returns on the falling edge after the transfer
  task automatic send_texel(int x, int y, bit typed, logic [VALUE_W-1:0] mist);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {4'b0, y[COORD_W-1:0], x[COORD_W-1:0]};
    texel_typed = typed;
    texel_mist = mist;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  // oldest expectation pops before the new one is queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_mist.size() == 0) begin
          flag_failure("unexpected mist_value", -1, out_tdata);
        end else begin
          mist_want = pending_mist.pop_front();
          if (out_tdata !== mist_want) begin
            flag_failure("mist_value", mist_want, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_mist.push_back(texel_typed ? texel_mist :
                               mist_of(in_tdata[COORD_W-1:0],
                                       in_tdata[2*COORD_W-1:COORD_W]));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [REG_W-1:0] readback;
    logic [REG_W-1:0] seed;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    read_seed_reg(int'(tvn_pkg::REG_SEED_COARSE), readback);
    if (readback !== tvn_pkg::SEED_COARSE_RESET) flag_failure("seed_coarse reset", 11, readback);
    read_seed_reg(int'(tvn_pkg::REG_SEED_MIDDLE), readback);
    if (readback !== tvn_pkg::SEED_MIDDLE_RESET) flag_failure("seed_middle reset", 13, readback);
    read_seed_reg(int'(tvn_pkg::REG_SEED_FINE), readback);
    if (readback !== tvn_pkg::SEED_FINE_RESET) flag_failure("seed_fine reset", 17, readback);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_seed_reg(directed_rows[i].a, directed_rows[i].b);
      end else begin
        send_texel(directed_rows[i].a, directed_rows[i].b, directed_rows[i].typed,
                   directed_rows[i].mist);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      for (int r = 0; r < UNMAPPED_REG; r++) begin
        case ($urandom_range(3))
          0: seed = '0;
          1: seed = '1;
          default: seed = $urandom;
        endcase
        write_seed_reg(r, seed);
      end
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      repeat (PHASE_TEXELS) begin
        send_texel($urandom_range(COORD_MAX), $urandom_range(COORD_MAX), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (tvn_pkg::PIPE_DEPTH + 4) @(negedge clk);
    if (fail_count == 0 && pending_mist.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
